// ----- rtl/core/dual_tap_varispeed_pitch_shifter_core_macros.svh -----
// Assertion macros for the pitch shifter core.
// Used by dtvps_ctrl in this folder; no other dependencies.
`ifndef DUAL_TAP_VARISPEED_PITCH_SHIFTER_CORE_MACROS_SVH
`define DUAL_TAP_VARISPEED_PITCH_SHIFTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check an expression at every clock edge outside reset
`define DTVPS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("dtvps assertion failed");
// Check a same-cycle implication
`define DTVPS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtvps assertion failed");
// Check a next-cycle implication
`define DTVPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtvps assertion failed");
`else
`define DTVPS_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define DTVPS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define DTVPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/dtvps_pkg.sv -----
// Shared types, constants and the quarter-sine table of the pitch shifter.
// No dependencies.
`default_nettype none

package dtvps_pkg;

  localparam int RING_DEPTH_DEF  = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RATIO = 4'd1;
  localparam int CFG_DATA_W = 17;

  localparam logic [9:0]  HALF_WINDOW_RST = 10'd512;
  localparam logic [16:0] RATIO_RST       = 17'd16384;
  localparam logic [16:0] RATIO_MIN       = 17'd4096;
  localparam logic [16:0] RATIO_MAX       = 17'd65536;

  // Datapath operation codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 5'd1;
  localparam logic [OP_W-1:0] OP_START  = 5'd2;
  localparam logic [OP_W-1:0] OP_MOD    = 5'd3;
  localparam logic [OP_W-1:0] OP_SETUP  = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV    = 5'd5;
  localparam logic [OP_W-1:0] OP_GAIN   = 5'd6;
  localparam logic [OP_W-1:0] OP_GSQ    = 5'd7;
  localparam logic [OP_W-1:0] OP_SQINIT = 5'd8;
  localparam logic [OP_W-1:0] OP_SQRT   = 5'd9;
  localparam logic [OP_W-1:0] OP_RD     = 5'd10;
  localparam logic [OP_W-1:0] OP_COEF   = 5'd11;
  localparam logic [OP_W-1:0] OP_HMUL   = 5'd12;
  localparam logic [OP_W-1:0] OP_H1     = 5'd13;
  localparam logic [OP_W-1:0] OP_H2     = 5'd14;
  localparam logic [OP_W-1:0] OP_TAP    = 5'd15;
  localparam logic [OP_W-1:0] OP_MIXA   = 5'd16;
  localparam logic [OP_W-1:0] OP_MIXB   = 5'd17;
  localparam logic [OP_W-1:0] OP_OUT    = 5'd18;
  localparam logic [OP_W-1:0] OP_FIX    = 5'd19;
  localparam logic [OP_W-1:0] OP_DONE   = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      slot;  // point of the four-point kernel being read
    logic            tap;   // 0: tap A, 1: tap B
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;  // last iteration of the serial unit
    logic clr_last;  // last entry of the clearing pass
    logic fix_ok;    // next sweep lies inside the window
    logic out_full;  // result register holds an item
  } sts_t;

  // Quarter-sine table, sin(k*pi/512) in Q15, built by a Taylor series in Q30
  localparam int SINE_ENTRIES = 257;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156};

  typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned x, x2, term, acc;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x    = (longint'(k) * PI_Q30) >> 9;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int j = 0; j < 6; j++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[j];
        if ((j % 2) == 0) acc = acc - term;
        else              acc = acc + term;
      end
      rom[k] = 16'((acc + 64'd16384) >> 15);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ----- rtl/core/dual_tap_varispeed_pitch_shifter_core.sv -----
// Two-tap delay-line pitch shifter: one sample in, one crossfaded sample out.
// Each item runs the serial modulo (10 steps), divider (16) and square root (16),
// the eight ring reads and nine multiplies through one read port and one
// multiplier, and up to two wrap corrections of the sweep, before the next
// ready. While the result still waits in its register the next item holds
// there. After reset a clearing pass zeroes all RING_DEPTH ring entries first.
`default_nettype none

module dual_tap_varispeed_pitch_shifter_core
  import dtvps_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int DB = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DB-1:0]         s_axis_tdata,   // sample_in, zero padding
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DB-1:0]         m_axis_tdata,   // sample_out, zero padding
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic signed [SAMPLE_BITS-1:0] out_data;

  // Configuration writes are taken at once
  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = DB'(unsigned'(out_data));

  dtvps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtvps_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample_in (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dtvps_ctrl.sv -----
// Sequencer of the pitch shifter: issues one datapath operation per cycle.
// Depends on dtvps_pkg and the assertion macro header.
`default_nettype none
`include "dual_tap_varispeed_pitch_shifter_core_macros.svh"

module dtvps_ctrl
  import dtvps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_MOD    = 5'd2;
  localparam logic [4:0] S_SETUP  = 5'd3;
  localparam logic [4:0] S_DIV    = 5'd4;
  localparam logic [4:0] S_GAIN   = 5'd5;
  localparam logic [4:0] S_GSQ    = 5'd6;
  localparam logic [4:0] S_SQINIT = 5'd7;
  localparam logic [4:0] S_SQRT   = 5'd8;
  localparam logic [4:0] S_RD     = 5'd9;
  localparam logic [4:0] S_WAIT   = 5'd10;
  localparam logic [4:0] S_COEF   = 5'd11;
  localparam logic [4:0] S_HM1    = 5'd12;
  localparam logic [4:0] S_H1     = 5'd13;
  localparam logic [4:0] S_HM2    = 5'd14;
  localparam logic [4:0] S_H2     = 5'd15;
  localparam logic [4:0] S_HM3    = 5'd16;
  localparam logic [4:0] S_TAP    = 5'd17;
  localparam logic [4:0] S_MIXA   = 5'd18;
  localparam logic [4:0] S_MIXB   = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;
  localparam logic [4:0] S_FIX    = 5'd21;

  logic [4:0] state, state_next;
  logic [1:0] rd_k, rd_k_next;
  logic       tap_sel, tap_sel_next;

  assign in_ready = (state == S_IDLE);

  // Next state and the operation for this cycle
  always_comb begin
    state_next   = state;
    rd_k_next    = rd_k;
    tap_sel_next = tap_sel;
    cmd.op       = OP_NOP;
    cmd.slot     = rd_k;
    cmd.tap      = tap_sel;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_START;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (sts.cnt_zero) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.op     = OP_SETUP;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.cnt_zero) state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = S_GSQ;
      end
      S_GSQ: begin
        cmd.op     = OP_GSQ;
        state_next = S_SQINIT;
      end
      S_SQINIT: begin
        cmd.op     = OP_SQINIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (sts.cnt_zero) begin
          state_next   = S_RD;
          rd_k_next    = 2'd0;
          tap_sel_next = 1'b0;
        end
      end
      S_RD: begin
        cmd.op    = OP_RD;
        rd_k_next = rd_k + 2'd1;
        if (rd_k == 2'd3) state_next = S_WAIT;
      end
      S_WAIT:  state_next = S_COEF;
      S_COEF: begin
        cmd.op     = OP_COEF;
        state_next = S_HM1;
      end
      S_HM1: begin
        cmd.op     = OP_HMUL;
        state_next = S_H1;
      end
      S_H1: begin
        cmd.op     = OP_H1;
        state_next = S_HM2;
      end
      S_HM2: begin
        cmd.op     = OP_HMUL;
        state_next = S_H2;
      end
      S_H2: begin
        cmd.op     = OP_H2;
        state_next = S_HM3;
      end
      S_HM3: begin
        cmd.op     = OP_HMUL;
        state_next = S_TAP;
      end
      S_TAP: begin
        cmd.op = OP_TAP;
        if (tap_sel) begin
          state_next = S_MIXA;
        end else begin
          tap_sel_next = 1'b1;
          rd_k_next    = 2'd0;
          state_next   = S_RD;
        end
      end
      S_MIXA: begin
        cmd.op     = OP_MIXA;
        state_next = S_MIXB;
      end
      S_MIXB: begin
        cmd.op     = OP_MIXB;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (!sts.out_full) begin
          cmd.op     = OP_OUT;
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        if (sts.fix_ok) begin
          cmd.op     = OP_DONE;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_FIX;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      rd_k    <= 2'd0;
      tap_sel <= 1'b0;
    end else begin
      state   <= state_next;
      rd_k    <= rd_k_next;
      tap_sel <= tap_sel_next;
    end
  end

  `DTVPS_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == S_MOD)
  `DTVPS_ASSERT_IMPL(a_out_free, clk, rst, cmd.op == OP_OUT, !sts.out_full)
  `DTVPS_ASSERT_IMPL(a_done_in_window, clk, rst, cmd.op == OP_DONE, sts.fix_ok)

endmodule

`default_nettype wire

// ----- rtl/core/dtvps_dp.sv -----
// Datapath of the pitch shifter: history ring, serial modulo, divider and
// square root, shared multiplier, tap interpolation and mixing.
// Depends on dtvps_pkg.
`default_nettype none

module dtvps_dp
  import dtvps_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_data
);

  localparam int AW = $clog2(RING_DEPTH);  // the user must keep ring depth a power of two; not enforced here
  localparam int EW = (AW > 13) ? AW : 13;
  localparam int TW = SAMPLE_BITS + 16;    // interpolation word
  localparam int PW = TW + 18;             // product word
  localparam int SW = TW + 19;             // mix sum word
  localparam logic signed [PW-1:0] RND16 = PW'(32'h8000);
  localparam logic signed [PW-1:0] RND17 = PW'(32'h10000);
  localparam logic signed [SW-1:0] RND23 = SW'(32'h400000);
  localparam logic signed [SW-1:0] Y_MAX = SW'({(SAMPLE_BITS-1){1'b1}});
  localparam logic signed [SW-1:0] Y_MIN = ~Y_MAX;

  // Configuration and sweep state
  logic [9:0]  half_window;
  logic [16:0] ratio;
  logic [26:0] sweep;
  logic [AW-1:0] wi, clr;

  // Serial units
  logic [3:0]  cnt;
  logic [26:0] rem, a_pos, b_pos, drem;
  logic [15:0] quo, ga;
  logic [31:0] sq_v, sq_res;
  logic signed [28:0] nxt;

  // Ring and kernel registers
  logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ring_q, sample;
  logic signed [SAMPLE_BITS-1:0] p [4];
  logic                          rd_pend;
  logic [1:0]                    rd_slot;
  logic signed [TW-1:0] c1, c2, h, tap_a, tap_b;
  logic signed [PW-1:0] prod, acc;

  // Window geometry
  logic [9:0]  hw_eff;
  logic [26:0] halfq, winq;
  assign hw_eff = (half_window == 10'd0) ? 10'd1 : half_window;
  assign halfq  = {1'b0, hw_eff, 16'b0};
  assign winq   = {hw_eff, 17'b0};

  // Modulo step: subtract the window shifted by the count
  logic [36:0] mod_sh, mod_x;
  assign mod_sh = {10'b0, winq} << cnt;
  assign mod_x  = {10'b0, rem};

  // Division step: one quotient bit of phase = a * 2^16 / window
  logic [27:0] d2, d2_sub;
  logic        d_ge;
  assign d2     = {drem, 1'b0};
  assign d_ge   = d2 >= {1'b0, winq};
  assign d2_sub = d2 - {1'b0, winq};

  // Gain A from the quarter-sine table
  logic [16:0] ph_fold;
  logic [8:0]  s_idx, s_idx_hi;
  logic [6:0]  s_frac;
  logic [15:0] s_lo, s_hi, ga_calc;
  logic [23:0] s_lerp;
  always_comb begin
    ph_fold  = (quo > 16'd32768) ? (17'd65536 - {1'b0, quo}) : {1'b0, quo};
    s_idx    = ph_fold[15:7];
    s_frac   = ph_fold[6:0];
    s_idx_hi = (s_idx == 9'd256) ? s_idx : s_idx + 9'd1;
    s_lo     = SINE_ROM[s_idx];
    s_hi     = SINE_ROM[s_idx_hi];
    s_lerp   = 24'(s_hi - s_lo) * {17'b0, s_frac} + 24'd64;
    if (s_idx == 9'd256) ga_calc = s_lo;
    else                 ga_calc = s_lo + s_lerp[22:7];
    if (ga_calc > 16'd32768) ga_calc = 16'd32768;
  end

  // Square root step
  logic [31:0] sq_bit, sq_trial;
  assign sq_bit   = 32'd1 << {cnt, 1'b0};
  assign sq_trial = sq_res + sq_bit;

  // Ring read address for the selected tap and kernel point
  logic [26:0] pos;
  logic [12:0] delay;
  logic [EW-1:0] raddr_full;
  logic [AW-1:0] raddr;
  assign pos        = cmd.tap ? b_pos : a_pos;
  assign delay      = {2'b0, pos[26:16]} + 13'd1 + {11'b0, cmd.slot};
  assign raddr_full = EW'(wi) - EW'(delay);
  assign raddr      = raddr_full[AW-1:0];

  // Catmull-Rom coefficients
  logic signed [TW-1:0] e0, e1, e2, e3, c1_calc, c2_calc, c3_calc;
  assign e0      = TW'(p[0]);
  assign e1      = TW'(p[1]);
  assign e2      = TW'(p[2]);
  assign e3      = TW'(p[3]);
  assign c1_calc = e2 - e0;
  assign c2_calc = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign c3_calc = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;

  // Shared multiplier
  logic signed [TW-1:0] mx;
  logic signed [17:0]   my;
  logic signed [PW-1:0] mul;
  always_comb begin
    mx = h;
    my = {2'b0, pos[15:0]};
    unique case (cmd.op)
      OP_GSQ: begin
        mx = TW'({1'b0, ga});
        my = {2'b0, ga};
      end
      OP_MIXA: begin
        mx = tap_a;
        my = {2'b0, ga};
      end
      OP_MIXB: begin
        mx = tap_b;
        my = {2'b0, sq_res[15:0]};
      end
      default: begin
        mx = h;
        my = {2'b0, pos[15:0]};
      end
    endcase
  end
  assign mul = PW'(mx) * PW'(my);

  // Rounded rescales of the product
  logic signed [PW-1:0] p16, p17;
  assign p16 = prod + RND16;
  assign p17 = prod + RND17;

  // Mix, round and saturate
  logic signed [SW-1:0] mix_sum, y;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  always_comb begin
    mix_sum = SW'(acc) + SW'(prod) + RND23;
    y       = mix_sum >>> 23;
    if (y > Y_MAX)      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    else if (y < Y_MIN) y_sat = Y_MIN[SAMPLE_BITS-1:0];
    else                y_sat = y[SAMPLE_BITS-1:0];
  end

  // Sweep step of (1 - ratio) in Q16
  logic [16:0] r_clamp;
  logic signed [19:0] step;
  logic signed [28:0] nxt_calc, winq_s;
  always_comb begin
    if (ratio < RATIO_MIN)      r_clamp = RATIO_MIN;
    else if (ratio > RATIO_MAX) r_clamp = RATIO_MAX;
    else                        r_clamp = ratio;
    step     = (20'sd16384 - signed'({3'b0, r_clamp})) <<< 2;
    nxt_calc = signed'({2'b0, a_pos}) + 29'(step);
    winq_s   = signed'({2'b0, winq});
  end

  assign sts.cnt_zero = (cnt == 4'd0);
  assign sts.clr_last = (clr == AW'(RING_DEPTH - 1));
  assign sts.fix_ok   = !nxt[28] && (nxt < winq_s);
  assign sts.out_full = out_valid;

  // Ring memory: one write port, one registered read port
  logic                          ring_we;
  logic [AW-1:0]                 waddr;
  logic signed [SAMPLE_BITS-1:0] wdata;
  assign ring_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_OUT);
  assign waddr   = (cmd.op == OP_CLEAR) ? clr : wi;
  assign wdata   = (cmd.op == OP_CLEAR) ? '0 : sample;

  always_ff @(posedge clk) begin
    if (ring_we) ring[waddr] <= wdata;
    if (cmd.op == OP_RD) ring_q <= ring[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= HALF_WINDOW_RST;
      ratio       <= RATIO_RST;
      sweep       <= {1'b0, HALF_WINDOW_RST, 16'b0};
      wi          <= '0;
      clr         <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_HALF_WINDOW) half_window <= cfg_data[9:0];
      if (cfg_we && cfg_index == CFG_PITCH_RATIO) ratio <= cfg_data;
      if (cmd.op == OP_CLEAR) clr <= clr + AW'(1);
      if (cmd.op == OP_OUT) wi <= wi + AW'(1);
      if (cmd.op == OP_DONE) sweep <= nxt[26:0];
      if (cmd.op == OP_OUT)  out_valid <= 1'b1;
      else if (out_ready)    out_valid <= 1'b0;
      rd_pend <= (cmd.op == OP_RD);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rd_pend) p[rd_slot] <= ring_q;
    if (cmd.op == OP_RD) rd_slot <= cmd.slot;
    unique case (cmd.op)
      OP_START: begin
        sample <= sample_in;
        rem    <= sweep;
        cnt    <= 4'd9;
      end
      OP_MOD: begin
        if (mod_x >= mod_sh) rem <= 27'(mod_x - mod_sh);
        cnt <= cnt - 4'd1;
      end
      OP_SETUP: begin
        a_pos <= rem;
        b_pos <= (rem < halfq) ? rem + halfq : rem - halfq;
        drem  <= rem;
        quo   <= '0;
        cnt   <= 4'd15;
      end
      OP_DIV: begin
        drem <= d_ge ? d2_sub[26:0] : d2[26:0];
        quo  <= {quo[14:0], d_ge};
        cnt  <= cnt - 4'd1;
      end
      OP_GAIN: ga <= ga_calc;
      OP_GSQ:  prod <= mul;
      OP_SQINIT: begin
        sq_v   <= 32'h4000_0000 - prod[31:0];
        sq_res <= '0;
        cnt    <= 4'd15;
      end
      OP_SQRT: begin
        if (sq_v >= sq_trial) begin
          sq_v   <= sq_v - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        cnt <= cnt - 4'd1;
      end
      OP_COEF: begin
        c1 <= c1_calc;
        c2 <= c2_calc;
        h  <= c3_calc <<< 8;
      end
      OP_HMUL: prod <= mul;
      OP_H1:   h <= (c2 <<< 8) + p16[TW+15:16];
      OP_H2:   h <= (c1 <<< 8) + p16[TW+15:16];
      OP_TAP: begin
        if (cmd.tap) tap_b <= (e1 <<< 8) + p17[TW+16:17];
        else         tap_a <= (e1 <<< 8) + p17[TW+16:17];
      end
      OP_MIXA: prod <= mul;
      OP_MIXB: begin
        acc  <= prod;
        prod <= mul;
      end
      OP_OUT: begin
        out_data <= y_sat;
        nxt      <= nxt_calc;
      end
      OP_FIX: begin
        if (nxt[28]) nxt <= nxt + winq_s;
        else         nxt <= nxt - winq_s;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- sim/dual_tap_varispeed_pitch_shifter_core_tb.sv -----
// Self-checking testbench for the dual-tap pitch shifter core.
// Depends on dtvps_pkg and dual_tap_varispeed_pitch_shifter_core.
`default_nettype none

module dual_tap_varispeed_pitch_shifter_core_tb;
  import dtvps_pkg::*;

  localparam int DEPTH = 2048;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // sample_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // sample_out
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dual_tap_varispeed_pitch_shifter_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shifter state mirror
  logic signed [15:0] history [DEPTH];
  logic [10:0] wr_slot;
  logic [31:0] sweep;
  logic [9:0]  win_half;
  logic [16:0] speed_q14;
  logic [15:0] sine_tab [SINE_ENTRIES];

  logic signed [15:0] shifted_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  stall_enable = 1'b1;

  function automatic longint round_shift(longint x, int s);
    longint v;
    v = x + (longint'(1) << (s - 1));
    return v >>> s;
  endfunction

  function automatic longint hist_at(int dly);
    return history[(int'(wr_slot) + DEPTH - (dly % DEPTH)) % DEPTH];
  endfunction

  // Catmull-Rom read at delay 2 + pos, Q8 result
  function automatic longint tap_value(logic [31:0] pos);
    int n;
    longint t, p0, p1, p2, p3, c1, c2, c3, h;
    n = 2 + int'(pos >> 16);
    t = longint'(pos[15:0]);
    p0 = hist_at(n - 1); p1 = hist_at(n); p2 = hist_at(n + 1); p3 = hist_at(n + 2);
    c1 = p2 - p0;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c3 = 3 * (p1 - p2) + p3 - p0;
    h = c3 * 256;
    h = c2 * 256 + round_shift(h * t, 16);
    h = c1 * 256 + round_shift(h * t, 16);
    h = round_shift(h * t, 17);
    return p1 * 256 + h;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0; bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv; res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Compute the shifted sample for one input and advance the mirror
  task automatic shift_sample(input logic signed [15:0] smp);
    longint unsigned hw, halfq, winq, a, b, phase, idx, frac, ga, gb, r;
    longint acc, y, nxt;
    hw = (win_half == 0) ? 1 : win_half;
    halfq = hw << 16;
    winq = 2 * halfq;
    a = sweep % winq;
    b = (a < halfq) ? a + halfq : a - halfq;
    phase = (a << 16) / winq;
    if (phase > 32768) phase = 65536 - phase;
    idx = phase >> 7;
    frac = phase & 127;
    if (idx >= SINE_ENTRIES - 1) ga = sine_tab[SINE_ENTRIES - 1];
    else ga = sine_tab[idx] + (((sine_tab[idx+1] - sine_tab[idx]) * frac + 64) >> 7);
    if (ga > 32768) ga = 32768;
    gb = int_sqrt((64'd1 << 30) - ga * ga);
    acc = longint'(ga) * tap_value(a) + longint'(gb) * tap_value(b);
    y = round_shift(acc, 23);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    shifted_q.push_back(16'(y));
    history[wr_slot] = smp;
    wr_slot = wr_slot + 1'b1;
    r = speed_q14;
    if (r < 4096) r = 4096;
    if (r > 65536) r = 65536;
    nxt = longint'(a) + (longint'(16384) - longint'(r)) * 4;
    nxt = nxt % longint'(winq);
    if (nxt < 0) nxt += longint'(winq);
    sweep = 32'(nxt);
  endtask

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  task automatic send_sample(input logic signed [15:0] smp, input bit gaps);
    int g;
    if (gaps) begin
      g = gap_len();
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk); while (!s_axis_tready);
    shift_sample(smp);
    // drop valid before offering the next item
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (shifted_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ix, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (ix == CFG_HALF_WINDOW) win_half = val[9:0];
    else if (ix == CFG_PITCH_RATIO) speed_q14 = val;
  endtask

  task automatic set_mode(input logic [9:0] hw, input logic [16:0] ratio);
    wait_drained();
    write_reg(CFG_HALF_WINDOW, hw);
    write_reg(CFG_PITCH_RATIO, ratio);
  endtask

  // Extremes, alternating bits, impulse and steady values
  task automatic test_directed();
    logic signed [15:0] pats [12] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
      16'sh5555, 16'shaaaa, 16'sh0001, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh1234};
    foreach (pats[i]) send_sample(pats[i], 1'b0);
  endtask

  // Small window with saturating loud square wave, then a zero half window with random samples
  task automatic test_small_window();
    set_mode(10'd3, 17'd0);
    for (int i = 0; i < 12; i++) send_sample(i[1] ? 16'sh7fff : 16'sh8000, 1'b1);
    set_mode(10'd0, 17'd131071);
    for (int i = 0; i < 10; i++) send_sample(16'($urandom), 1'b1);
  endtask

  task automatic test_random_run(input int count);
    for (int i = 0; i < count; i++) send_sample(16'($urandom), 1'b1);
  endtask

  // Receiver holds off long so the core fills and stalls its input
  task automatic test_backpressure();
    hold_off = 1'b1;
    test_random_run(6);
    wait (!hold_off);
    wait_drained();
  endtask

  initial begin
    sine_tab = SINE_ROM;
    foreach (history[i]) history[i] = '0;
    wr_slot = '0;
    win_half = HALF_WINDOW_RST;
    speed_q14 = RATIO_RST;
    sweep = 32'(HALF_WINDOW_RST) << 16;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_small_window();
    set_mode(10'd1020, 17'd4096);
    test_random_run(120);
    set_mode(10'd1, 17'd65536);
    test_random_run(100);
    test_backpressure();
    set_mode(10'd512, 17'd20000);
    test_random_run(100);
    set_mode(10'd100, 17'd10000);
    test_random_run(100);
    for (int k = 0; k < 4; k++) begin
      set_mode(10'($urandom_range(1, 1023)), 17'($urandom));
      test_random_run(60);
    end
    wait_drained();
    if (errors == 0) $display("dual_tap_varispeed_pitch_shifter_core regression: pass");
    else $display("dual_tap_varispeed_pitch_shifter_core regression: fail");
    $finish;
  end

  // Drive the result-side ready with random stalls and a long hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Compare each accepted item against the oldest expectation
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (shifted_q.size() == 0) begin
        $error("unexpected item sample_out=%0d", $signed(m_axis_tdata));
        errors++;
      end else begin
        want = shifted_q.pop_front();
        if (m_axis_tdata !== want) begin
          $error("sample_out expected %0d actual %0d", want, $signed(m_axis_tdata));
          errors++;
        end
      end
    end
  end

  // End the run after too long without any handshake on the input, result or configuration ports
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dual_tap_varispeed_pitch_shifter_core regression: fail");
      $finish;
    end
  end

endmodule

`default_nettype wire
